>>> design/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg - shared types and constants for the midpoint subdivider
// Corner record, field widths and the index offset table.
// ----------------------------------------------------------------------------
package tms_pkg;

    localparam int TRI_W             = 14;     // triangle number width
    localparam int MAX_TRIANGLES_DEF = 10922;  // last base must fit 16 bits
    localparam int RES_W             = 5;      // result counter, 0..17
    localparam int RES_LAST          = 17;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [16:0] tu;
        logic [16:0] tv;
    } t_corner;

    // offset from the base for each of the eighteen results
    function automatic logic [2:0] idx_ofs(input logic [RES_W-1:0] k);
        logic [2:0] o;
        case (k)
            5'd0:    o = 3'd0;
            5'd1:    o = 3'd1;
            5'd2:    o = 3'd2;
            5'd3:    o = 3'd3;
            5'd4:    o = 3'd4;
            5'd5:    o = 3'd5;
            5'd6:    o = 3'd0;
            5'd7:    o = 3'd3;
            5'd8:    o = 3'd5;
            5'd9:    o = 3'd5;
            5'd10:   o = 3'd3;
            5'd11:   o = 3'd4;
            5'd12:   o = 3'd5;
            5'd13:   o = 3'd4;
            5'd14:   o = 3'd2;
            5'd15:   o = 3'd3;
            5'd16:   o = 3'd1;
            5'd17:   o = 3'd4;
            default: o = 3'd0;
        endcase
        return o;
    endfunction

endpackage

>>> design/triangle_midpoint_subdivider.sv
// ----------------------------------------------------------------------------
// triangle_midpoint_subdivider - splits each triangle into four
// Gathers three corners, emits six vertices and twelve indices per triangle.
// ----------------------------------------------------------------------------
//  channel | direction | valid   | stall   | payload
//  corner  | in        | i_valid | o_stall | i_first_corner_of_mesh, pos, nrm, tex
//  result  | out       | o_valid | i_stall | o_item_kind .. o_last_of_run
//
//  First and second corners are just stored. A third corner starts a run of
//  eighteen result beats, or is dropped once MAX_TRIANGLES triangles are
//  taken. Each midpoint normal is built on the one shared 17x17 multiplier:
//  3 squares for the length, then, unless that length is zero, per component
//  the square and top quotient bit, 30 restoring divide steps and a 15-step
//  square-root search.
//  Synchronous active-low reset clears the sequencer, corner count and
//  triangle number. Input stall is high for the whole run; a stalled result
//  beat holds until taken.
module triangle_midpoint_subdivider #(
    parameter int MAX_TRIANGLES = tms_pkg::MAX_TRIANGLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_first_corner_of_mesh,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [15:0] i_nrm_x,
    input  logic signed [15:0] i_nrm_y,
    input  logic signed [15:0] i_nrm_z,
    input  logic        [16:0] i_tex_u,
    input  logic        [16:0] i_tex_v,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_item_kind,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [15:0] o_out_nrm_x,
    output logic signed [15:0] o_out_nrm_y,
    output logic signed [15:0] o_out_nrm_z,
    output logic        [16:0] o_out_tex_u,
    output logic        [16:0] o_out_tex_v,
    output logic        [15:0] o_index_value,
    output logic               o_last_of_run
);
    import tms_pkg::*;

    localparam logic [TRI_W-1:0] MAX_T = TRI_W'(MAX_TRIANGLES);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PICK = 4'd1;  // choose what the next beat is
    localparam logic [3:0] S_LEN  = 4'd2;  // squared length of normal sum
    localparam logic [3:0] S_SQ   = 4'd3;  // component square, first quotient bit
    localparam logic [3:0] S_DIV  = 4'd4;  // restoring divide
    localparam logic [3:0] S_SQRT = 4'd5;  // rounded root search
    localparam logic [3:0] S_MOUT = 4'd6;  // load midpoint into output
    localparam logic [3:0] S_OUT  = 4'd7;  // beat on offer

    logic [3:0]       r_state, n_state;
    logic [1:0]       r_phase, n_phase;
    logic [TRI_W-1:0] r_tri, n_tri;
    logic [RES_W-1:0] r_k, n_k;
    logic [15:0]      r_base, n_base;
    t_corner          r_c0, n_c0, r_c1, n_c1, r_c2, n_c2;

    // midpoint working set
    logic signed [16:0] r_s [3];
    logic signed [16:0] n_s [3];
    logic signed [15:0] r_nrm [3];
    logic signed [15:0] n_nrm [3];
    logic [31:0] r_mpx, n_mpx, r_mpy, n_mpy, r_mpz, n_mpz;
    logic [16:0] r_mtu, n_mtu, r_mtv, n_mtv;
    logic [1:0]  r_ci, n_ci;
    logic [33:0] r_len2, n_len2;
    logic [33:0] r_rem, n_rem;
    logic [30:0] r_quot, n_quot;
    logic [4:0]  r_cnt, n_cnt;
    logic [14:0] r_q, n_q;
    logic [3:0]  r_bit, n_bit;

    // output register
    logic        r_oval, n_oval;
    logic        r_kind, n_kind;
    logic [31:0] r_opx, n_opx, r_opy, n_opy, r_opz, n_opz;
    logic [15:0] r_onx, n_onx, r_ony, n_ony, r_onz, n_onz;
    logic [16:0] r_otu, n_otu, r_otv, n_otv;
    logic [15:0] r_oidx, n_oidx;
    logic        r_olast, n_olast;

    // shared multiplier
    logic [16:0] mul_a;
    logic [33:0] prod;
    logic signed [16:0] s_sel;
    logic [16:0] s_mag;
    logic [14:0] cand;
    logic [15:0] d_odd;

    t_corner cin, ca, cb, cv;
    logic [1:0] mid_j;
    logic [1:0] eff_phase;
    logic [TRI_W-1:0] eff_tri;
    logic [32:0] sum_x, sum_y, sum_z;
    logic [17:0] sum_u, sum_v;
    logic [34:0] rem2;
    logic        ge;
    logic [33:0] sq_rem;
    logic        sq_ge;

    assign cin = '{px: i_pos_x, py: i_pos_y, pz: i_pos_z,
                   nx: i_nrm_x, ny: i_nrm_y, nz: i_nrm_z,
                   tu: i_tex_u, tv: i_tex_v};

    assign s_sel = r_s[r_ci];
    assign s_mag = s_sel[16] ? 17'(-s_sel) : 17'(s_sel);
    assign cand  = r_q | (15'd1 << r_bit);
    assign d_odd = {cand, 1'b0} - 16'd1;
    assign mul_a = (r_state == S_SQRT) ? {1'b0, d_odd} : s_mag;
    assign prod  = 34'(mul_a) * 34'(mul_a);

    // divide step: remainder always below the divisor
    assign rem2   = {r_rem, 1'b0};
    assign ge     = rem2 >= 35'(r_len2);
    assign sq_ge  = prod >= r_len2;
    assign sq_rem = sq_ge ? prod - r_len2 : prod;

    // corner selection: edges 1-2, 2-3, 3-1
    assign mid_j = 2'(r_k - RES_W'(3));
    always_comb begin
        unique case (mid_j)
            2'd0:    begin ca = r_c0; cb = r_c1; end
            2'd1:    begin ca = r_c1; cb = r_c2; end
            default: begin ca = r_c2; cb = r_c0; end
        endcase
        unique case (r_k[1:0])
            2'd0:    cv = r_c0;
            2'd1:    cv = r_c1;
            default: cv = r_c2;
        endcase
    end

    assign sum_x = {ca.px[31], ca.px} + {cb.px[31], cb.px};
    assign sum_y = {ca.py[31], ca.py} + {cb.py[31], cb.py};
    assign sum_z = {ca.pz[31], ca.pz} + {cb.pz[31], cb.pz};
    assign sum_u = {1'b0, ca.tu} + {1'b0, cb.tu};
    assign sum_v = {1'b0, ca.tv} + {1'b0, cb.tv};

    assign eff_phase = i_first_corner_of_mesh ? 2'd0 : r_phase;
    assign eff_tri   = i_first_corner_of_mesh ? '0 : r_tri;

    always_comb begin
        n_state = r_state; n_phase = r_phase; n_tri = r_tri; n_k = r_k;
        n_base = r_base; n_c0 = r_c0; n_c1 = r_c1; n_c2 = r_c2;
        n_s = r_s; n_nrm = r_nrm;
        n_mpx = r_mpx; n_mpy = r_mpy; n_mpz = r_mpz; n_mtu = r_mtu; n_mtv = r_mtv;
        n_ci = r_ci; n_len2 = r_len2; n_rem = r_rem; n_quot = r_quot;
        n_cnt = r_cnt; n_q = r_q; n_bit = r_bit;
        n_oval = r_oval; n_kind = r_kind;
        n_opx = r_opx; n_opy = r_opy; n_opz = r_opz;
        n_onx = r_onx; n_ony = r_ony; n_onz = r_onz;
        n_otu = r_otu; n_otv = r_otv; n_oidx = r_oidx; n_olast = r_olast;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_tri = eff_tri;
                    if (eff_phase == 2'd0) begin
                        n_c0 = cin; n_phase = 2'd1;
                    end else if (eff_phase == 2'd1) begin
                        n_c1 = cin; n_phase = 2'd2;
                    end else begin
                        n_phase = 2'd0;
                        if (eff_tri >= MAX_T) begin
                            n_tri = MAX_T;
                        end else begin
                            n_c2    = cin;
                            n_base  = {eff_tri, 2'b00} + {1'b0, eff_tri, 1'b0};
                            n_tri   = eff_tri + 1'b1;
                            n_k     = '0;
                            n_state = S_PICK;
                        end
                    end
                end
            end
            S_PICK: begin
                if (r_k < RES_W'(3)) begin
                    n_kind = 1'b0;
                    n_opx = cv.px; n_opy = cv.py; n_opz = cv.pz;
                    n_onx = cv.nx; n_ony = cv.ny; n_onz = cv.nz;
                    n_otu = cv.tu; n_otv = cv.tv;
                    n_oidx = r_base + 16'(idx_ofs(r_k)); n_olast = 1'b0;
                    n_oval = 1'b1; n_state = S_OUT;
                end else if (r_k < RES_W'(6)) begin
                    n_mpx = sum_x[32:1]; n_mpy = sum_y[32:1]; n_mpz = sum_z[32:1];
                    n_mtu = sum_u[17:1]; n_mtv = sum_v[17:1];
                    n_s[0] = 17'($signed(ca.nx)) + 17'($signed(cb.nx));
                    n_s[1] = 17'($signed(ca.ny)) + 17'($signed(cb.ny));
                    n_s[2] = 17'($signed(ca.nz)) + 17'($signed(cb.nz));
                    n_len2 = '0; n_ci = 2'd0; n_state = S_LEN;
                end else begin
                    n_kind = 1'b1;
                    n_opx = '0; n_opy = '0; n_opz = '0;
                    n_onx = '0; n_ony = '0; n_onz = '0;
                    n_otu = '0; n_otv = '0;
                    n_oidx = r_base + 16'(idx_ofs(r_k));
                    n_olast = (r_k == RES_W'(RES_LAST));
                    n_oval = 1'b1; n_state = S_OUT;
                end
            end
            S_LEN: begin
                n_len2 = r_len2 + prod;
                if (r_ci == 2'd2) begin
                    n_ci = 2'd0; n_state = S_SQ;
                end else begin
                    n_ci = r_ci + 2'd1;
                end
            end
            S_SQ: begin
                if (r_len2 == '0) begin
                    n_nrm[0] = '0; n_nrm[1] = '0; n_nrm[2] = '0;
                    n_state = S_MOUT;
                end else begin
                    n_quot  = {30'd0, sq_ge};
                    n_rem   = sq_rem;
                    n_cnt   = 5'd29;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = 34'(ge ? rem2 - 35'(r_len2) : rem2);
                n_quot = {r_quot[29:0], ge};
                if (r_cnt == '0) begin
                    n_q = '0; n_bit = 4'd14; n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_SQRT: begin
                if (prod <= 34'(r_quot)) n_q = cand;
                if (r_bit == '0) begin
                    n_nrm[r_ci] = s_sel[16] ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});
                    if (r_ci == 2'd2) begin
                        n_state = S_MOUT;
                    end else begin
                        n_ci = r_ci + 2'd1; n_state = S_SQ;
                    end
                end else begin
                    n_bit = r_bit - 4'd1;
                end
            end
            S_MOUT: begin
                n_kind = 1'b0;
                n_opx = r_mpx; n_opy = r_mpy; n_opz = r_mpz;
                n_onx = r_nrm[0]; n_ony = r_nrm[1]; n_onz = r_nrm[2];
                n_otu = r_mtu; n_otv = r_mtv;
                n_oidx = r_base + 16'(idx_ofs(r_k)); n_olast = 1'b0;
                n_oval = 1'b1; n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_oval = 1'b0;
                    if (r_k == RES_W'(RES_LAST)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 1'b1; n_state = S_PICK;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_tri   <= '0;
            r_k     <= '0;
            r_oval  <= 1'b0;
            r_c0    <= '0;
            r_c1    <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_tri   <= n_tri;
            r_k     <= n_k;
            r_oval  <= n_oval;
            r_c0    <= n_c0;
            r_c1    <= n_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base; r_c2 <= n_c2;
        r_s <= n_s; r_nrm <= n_nrm;
        r_mpx <= n_mpx; r_mpy <= n_mpy; r_mpz <= n_mpz; r_mtu <= n_mtu; r_mtv <= n_mtv;
        r_ci <= n_ci; r_len2 <= n_len2; r_rem <= n_rem; r_quot <= n_quot;
        r_cnt <= n_cnt; r_q <= n_q; r_bit <= n_bit;
        r_kind <= n_kind; r_opx <= n_opx; r_opy <= n_opy; r_opz <= n_opz;
        r_onx <= n_onx; r_ony <= n_ony; r_onz <= n_onz;
        r_otu <= n_otu; r_otv <= n_otv; r_oidx <= n_oidx; r_olast <= n_olast;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_oval;
    assign o_item_kind   = r_kind;
    assign o_out_pos_x   = r_opx;
    assign o_out_pos_y   = r_opy;
    assign o_out_pos_z   = r_opz;
    assign o_out_nrm_x   = r_onx;
    assign o_out_nrm_y   = r_ony;
    assign o_out_nrm_z   = r_onz;
    assign o_out_tex_u   = r_otu;
    assign o_out_tex_v   = r_otv;
    assign o_index_value = r_oidx;
    assign o_last_of_run = r_olast;

`ifndef SYNTHESIS
    a_valid_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT))
        else $error("result valid outside offer state");
    a_last_is_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_run) |-> o_item_kind)
        else $error("last flag on a vertex beat");
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("corner count out of range");
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_of_run) |=> !o_stall)
        else $error("run did not end after last beat");
`endif

endmodule
